// ----- design/ldgp_pkg.sv -----
`default_nettype none

package ldgp_pkg;

  localparam int COORD_WIDTH = 13;
  localparam int CELL_WIDTH  = 8;

  localparam logic [7:0] LINE_SET_BIT = 8'h80;

  // Character codes with bit 7 stripped
  localparam logic [6:0] CH_A = 7'h61;
  localparam logic [6:0] CH_J = 7'h6A;
  localparam logic [6:0] CH_K = 7'h6B;
  localparam logic [6:0] CH_L = 7'h6C;
  localparam logic [6:0] CH_M = 7'h6D;
  localparam logic [6:0] CH_N = 7'h6E;
  localparam logic [6:0] CH_O = 7'h6F;
  localparam logic [6:0] CH_P = 7'h70;
  localparam logic [6:0] CH_Q = 7'h71;
  localparam logic [6:0] CH_R = 7'h72;
  localparam logic [6:0] CH_S = 7'h73;
  localparam logic [6:0] CH_T = 7'h74;
  localparam logic [6:0] CH_U = 7'h75;
  localparam logic [6:0] CH_V = 7'h76;
  localparam logic [6:0] CH_W = 7'h77;
  localparam logic [6:0] CH_X = 7'h78;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [CELL_WIDTH-1:0]  cell_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RECT  = 2'd1,
    KIND_HSPAN = 2'd2,
    KIND_VSPAN = 2'd3
  } kind_t;

  typedef struct packed {
    logic        handled;
    kind_t       kind;
    coord_t      pos_x;
    coord_t      pos_y;
    logic [7:0]  len;
    logic [7:0]  rect_h;
    logic [23:0] color;
    logic [7:0]  rop;
    logic        last;
  } prim_t;

  function automatic prim_t make_prim(kind_t kind, coord_t px, coord_t py, cell_t len,
                                      cell_t rh, logic [23:0] col, logic [7:0] rop,
                                      logic last);
    prim_t p;
    p.handled = (kind != KIND_NONE);
    p.kind    = kind;
    p.pos_x   = px;
    p.pos_y   = py;
    p.len     = 8'(len);
    p.rect_h  = 8'(rh);
    p.color   = col;
    p.rop     = rop;
    p.last    = last;
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- design/line_drawing_glyph_primitives_unit.sv -----
`default_nettype none

// Channel   Ports                               Handshake
// ------    ----------------------------------  -------------------------------------
// input     in_char_code .. in_raster_op        taken when start is high, busy low
// result    out_handled .. out_last             out_valid for one cycle, no back-pressure
//
// An item is registered on acceptance, decoded in the next cycle and its first
// primitive appears on the result ports in the cycle after that.
// Codes giving one primitive sustain one item per cycle; corners, tees and the
// cross hold the input register for a second decode pass, so busy is high for
// one cycle and no new item is taken while it is high.
// Synchronous reset clears the valid and phase flags; no result is lost or held.

module line_drawing_glyph_primitives_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire  [7:0]                    in_char_code,
  input  wire  [11:0]                   in_cell_x,
  input  wire  [11:0]                   in_cell_y,
  input  wire  [7:0]                    in_cell_w,
  input  wire  [7:0]                    in_cell_h,
  input  wire  [23:0]                   in_color,
  input  wire  [7:0]                    in_raster_op,
  output logic                          out_valid,
  output logic                          out_handled,
  output logic [1:0]                    out_prim_kind,
  output logic [ldgp_pkg::COORD_WIDTH-1:0] out_pos_x,
  output logic [ldgp_pkg::COORD_WIDTH-1:0] out_pos_y,
  output logic [7:0]                    out_span_len,
  output logic [7:0]                    out_rect_h,
  output logic [23:0]                   out_color,
  output logic [7:0]                    out_raster_op,
  output logic                          out_last
);

  localparam int CW = ldgp_pkg::COORD_WIDTH;
  localparam int EW = ldgp_pkg::CELL_WIDTH;

  // input register
  logic              in_valid_r, in_valid_nxt;
  logic              phase_r, phase_nxt;
  logic [7:0]        code_r;
  logic [11:0]       x_r, y_r;
  logic [7:0]        w_r, h_r;
  logic [23:0]       color_r;
  logic [7:0]        rop_r;

  // result register
  logic              out_valid_r, out_valid_nxt;
  ldgp_pkg::prim_t   prim_r, prim_nxt;

  // decode
  ldgp_pkg::cell_t   w_c, h_c, hw, hh, qh, lw, lh;
  ldgp_pkg::coord_t  x_c, y_c, xm, ym, yq, yr, ys;
  ldgp_pkg::prim_t   p0, p1;
  logic              two;
  logic              accept;

  always_comb begin
    w_c = EW'(w_r);
    h_c = EW'(h_r);
    hw  = w_c >> 1;
    hh  = h_c >> 1;
    qh  = h_c >> 2;
    lw  = hw + EW'(1);
    lh  = hh + EW'(1);
    x_c = CW'(x_r);
    y_c = CW'(y_r);
    xm  = x_c + CW'(hw);
    ym  = y_c + CW'(hh);
    yq  = y_c + CW'(qh);
    yr  = ym + CW'(qh);
    ys  = y_c + CW'(h_c) - CW'(1);
  end

  always_comb begin
    p0  = ldgp_pkg::make_prim(ldgp_pkg::KIND_NONE, '0, '0, '0, '0, '0, '0, 1'b1);
    p1  = p0;
    two = 1'b0;
    if ((code_r & ldgp_pkg::LINE_SET_BIT) != '0) begin
      unique case (code_r[6:0])
        ldgp_pkg::CH_A: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_RECT, x_c, y_c, w_c, h_c, color_r, '0, 1'b1);
        end
        ldgp_pkg::CH_J: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, lw, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, lh, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_K: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, lw, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, ym, lh, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_L: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, xm, ym, lw, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, ym, lh, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_M: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, xm, ym, lw, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, hh, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_N: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, w_c, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, h_c, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_O: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, y_c, w_c, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_P: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, yq, w_c, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_Q: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, w_c, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_R: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, yr, w_c, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_S: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ys, w_c, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_T: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, h_c, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, xm, ym, lw, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_U: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, h_c, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, lw, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_V: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, w_c, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, lh, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_W: begin
          two = 1'b1;
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_HSPAN, x_c, ym, w_c, '0, color_r, rop_r, 1'b0);
          p1 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, ym, lh, '0, color_r, rop_r, 1'b1);
        end
        ldgp_pkg::CH_X: begin
          p0 = ldgp_pkg::make_prim(ldgp_pkg::KIND_VSPAN, xm, y_c, h_c, '0, color_r, rop_r, 1'b1);
        end
        default: begin
          two = 1'b0;
        end
      endcase
    end
  end

  // hold the input register for the second pass of a two-primitive item
  assign busy   = in_valid_r & two & ~phase_r;
  assign accept = start & ~busy;

  always_comb begin
    in_valid_nxt  = accept | busy;
    phase_nxt     = busy;
    out_valid_nxt = in_valid_r;
    prim_nxt      = phase_r ? p1 : p0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_r  <= in_char_code;
      x_r     <= in_cell_x;
      y_r     <= in_cell_y;
      w_r     <= in_cell_w;
      h_r     <= in_cell_h;
      color_r <= in_color;
      rop_r   <= in_raster_op;
    end
    prim_r <= prim_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_handled   = prim_r.handled;
  assign out_prim_kind = prim_r.kind;
  assign out_pos_x     = prim_r.pos_x;
  assign out_pos_y     = prim_r.pos_y;
  assign out_span_len  = prim_r.len;
  assign out_rect_h    = prim_r.rect_h;
  assign out_color     = prim_r.color;
  assign out_raster_op = prim_r.rop;
  assign out_last      = prim_r.last;

endmodule

`default_nettype wire
